>>> rtl/core/stc_pkg.sv
package stc_pkg;

  localparam int CW   = 24;           // coordinate width
  localparam int FB   = 16;           // fraction bits of hit_fraction
  localparam int QW   = FB + 1;       // hit_fraction width
  localparam int DW   = CW + 1;       // coordinate difference width
  localparam int PW   = 2 * DW + 1;   // cross product component width
  localparam int LOW  = PW / 2;       // low slice of a cross component
  localparam int HIW  = PW - LOW;     // high slice of a cross component
  localparam int DOTW = DW + PW + 2;  // dot product width
  localparam int LAT  = 5 + QW;       // pipeline stages from start to done

  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_START_Z = 3'd2,
    REG_END_X   = 3'd3,
    REG_END_Y   = 3'd4,
    REG_END_Z   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] v0_x;
    logic signed [CW-1:0] v0_y;
    logic signed [CW-1:0] v0_z;
    logic signed [CW-1:0] v1_x;
    logic signed [CW-1:0] v1_y;
    logic signed [CW-1:0] v1_z;
    logic signed [CW-1:0] v2_x;
    logic signed [CW-1:0] v2_y;
    logic signed [CW-1:0] v2_z;
  } tri_in_t;

  typedef struct packed {
    logic          hit;
    logic [QW-1:0] hit_fraction;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] sz;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic signed [CW-1:0] ez;
  } seg_t;

  typedef logic [DW+LOW:0]   plo_t;
  typedef logic [DW+HIW-1:0] phi_t;

  // partial products of the four dot products: qp.n, ap.n, ac.e, ab.e
  typedef struct packed {
    logic            vld;
    plo_t [3:0][2:0] lo;
    phi_t [3:0][2:0] hi;
  } geo_t;

  typedef struct packed {
    logic            vld;
    logic            hit;
    logic [DOTW-1:0] r;
    logic [DOTW-1:0] d;
    logic [QW-1:0]   q;
  } divs_t;

endpackage

>>> rtl/core/segment_triangle_intersect.sv
// Segment / triangle intersection, one-sided, barycentric, exact integer math.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data write the segment
//   start (index 0..2) and end (3..5) points; other indexes are dropped.
//   cfg_ready is always high. Write only while no triangle is in flight.
// Input: a triangle transfer happens on a clock with start high and busy low.
//   busy is high only around reset, so one triangle per cycle is taken.
// Output: done pulses for one cycle with result; the receiver cannot stall,
//   so nothing backs up into the pipe.
// Throughput: 1 per cycle while busy is low.
//   Stages: differences, cross terms, split dot terms, dot sums, range
//   tests, then one restoring-division stage per quotient bit (17).
// Reset: synchronous, clears all stage valid bits and the segment points.
// hit_fraction = floor(t * 2^16 / d) on a hit, 0 on a miss.
module segment_triangle_intersect
  import stc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tri_in_t       triangle,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [CW-1:0] cfg_data,
  output logic          done,
  output result_t       result
);

  seg_t  seg;
  geo_t  geo;
  divs_t dv [QW+1];

  assign cfg_ready = 1'b1;

  // segment endpoint registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_START_X: seg.sx <= cfg_data;
        REG_START_Y: seg.sy <= cfg_data;
        REG_START_Z: seg.sz <= cfg_data;
        REG_END_X:   seg.ex <= cfg_data;
        REG_END_Y:   seg.ey <= cfg_data;
        REG_END_Z:   seg.ez <= cfg_data;
        default: ;
      endcase
    end
  end

  // held off while reset is applied; busy is a registered copy of rst
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  stc_geom u_geom (
    .clk    (clk),
    .rst    (rst),
    .in_vld (start && !busy),
    .tri_in (triangle),
    .seg    (seg),
    .geo    (geo)
  );

  stc_test u_test (
    .clk (clk),
    .rst (rst),
    .geo (geo),
    .dv  (dv[0])
  );

  // first stage takes the integer bit (t == d), the rest one fraction bit each
  for (genvar i = 0; i < QW; i++) begin : g_div
    stc_div_stage #(.FIRST(i == 0)) u_div (
      .clk  (clk),
      .rst  (rst),
      .din  (dv[i]),
      .dout (dv[i+1])
    );
  end

  assign done                = dv[QW].vld;
  assign result.hit          = dv[QW].hit;
  assign result.hit_fraction = dv[QW].hit ? dv[QW].q : '0;

  a_miss_zero : assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.hit_fraction == '0)
    else $error("miss with nonzero fraction");

  a_frac_range : assert property (@(posedge clk) disable iff (rst)
    done |-> result.hit_fraction <= QW'(1 << FB))
    else $error("fraction above one");

  a_busy_reset : assert property (@(posedge clk)
    rst |=> busy)
    else $error("busy low after reset");

endmodule

>>> rtl/core/stc_geom.sv
module stc_geom
  import stc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_vld,
  input  tri_in_t tri_in,
  input  seg_t    seg,
  output geo_t    geo
);

  logic signed [CW-1:0] a [3], b [3], c [3], s [3], f [3];
  logic signed [DW-1:0] ab1 [3], ac1 [3], qp1 [3], ap1 [3];
  logic signed [DW-1:0] ab2 [3], ac2 [3], qp2 [3], ap2 [3];
  logic signed [2*DW-1:0] pn [3][2], pe [3][2];
  logic signed [PW-1:0] n [3], e [3];
  logic signed [DW-1:0] vec [4][3];
  logic signed [PW-1:0] opn [4][3];
  logic vld1, vld2;

  always_comb begin
    a = '{tri_in.v0_x, tri_in.v0_y, tri_in.v0_z};
    b = '{tri_in.v1_x, tri_in.v1_y, tri_in.v1_z};
    c = '{tri_in.v2_x, tri_in.v2_y, tri_in.v2_z};
    s = '{seg.sx, seg.sy, seg.sz};
    f = '{seg.ex, seg.ey, seg.ez};
  end

  // stage 1: differences
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ab1[k] <= DW'(b[k]) - DW'(a[k]);
      ac1[k] <= DW'(c[k]) - DW'(a[k]);
      qp1[k] <= DW'(s[k]) - DW'(f[k]);
      ap1[k] <= DW'(s[k]) - DW'(a[k]);
    end
  end

  // stage 2: cross product terms, n = ab x ac, e = qp x ap
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pn[k][0] <= ab1[(k+1)%3] * ac1[(k+2)%3];
      pn[k][1] <= ab1[(k+2)%3] * ac1[(k+1)%3];
      pe[k][0] <= qp1[(k+1)%3] * ap1[(k+2)%3];
      pe[k][1] <= qp1[(k+2)%3] * ap1[(k+1)%3];
      ab2[k] <= ab1[k];
      ac2[k] <= ac1[k];
      qp2[k] <= qp1[k];
      ap2[k] <= ap1[k];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n[k] = PW'(pn[k][0]) - PW'(pn[k][1]);
      e[k] = PW'(pe[k][0]) - PW'(pe[k][1]);
      vec[0][k] = qp2[k];  opn[0][k] = n[k];
      vec[1][k] = ap2[k];  opn[1][k] = n[k];
      vec[2][k] = ac2[k];  opn[2][k] = e[k];
      vec[3][k] = ab2[k];  opn[3][k] = e[k];
    end
  end

  // stage 3: split products, cross component cut into low and high slices
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 3; k++) begin
        geo.lo[j][k] <= $signed(vec[j][k]) * $signed({1'b0, opn[j][k][LOW-1:0]});
        geo.hi[j][k] <= $signed(vec[j][k]) * $signed(opn[j][k][PW-1:LOW]);
      end
    end
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      geo.vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      vld2    <= vld1;
      geo.vld <= vld2;
    end
  end

endmodule

>>> rtl/core/stc_test.sv
module stc_test
  import stc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  geo_t  geo,
  output divs_t dv
);

  logic signed [DOTW-1:0] sum [4];
  logic signed [DOTW-1:0] dot [4];
  logic vld4;
  logic signed [DOTW:0]   w;
  logic signed [DOTW+1:0] vw;
  logic hit;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      sum[j] = '0;
      for (int k = 0; k < 3; k++) begin
        sum[j] = sum[j] + (DOTW'($signed(geo.hi[j][k])) <<< LOW)
                        + DOTW'($signed(geo.lo[j][k]));
      end
    end
  end

  // stage 4: dot products
  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) dot[j] <= sum[j];
  end

  // stage 5: range tests against d
  always_comb begin
    w   = -(DOTW+1)'(dot[3]);
    vw  = (DOTW+2)'(dot[2]) + (DOTW+2)'(w);
    hit = (dot[0] > 0) && (dot[1] >= 0) && (dot[1] <= dot[0])
       && (dot[2] >= 0) && (dot[2] <= dot[0])
       && (w >= 0) && (vw <= (DOTW+2)'(dot[0]));
  end

  always_ff @(posedge clk) begin
    dv.hit <= hit;
    dv.r   <= hit ? dot[1] : '0;
    dv.d   <= hit ? dot[0] : DOTW'(1);
    dv.q   <= '0;
    if (rst) begin
      vld4   <= 1'b0;
      dv.vld <= 1'b0;
    end else begin
      vld4   <= geo.vld;
      dv.vld <= vld4;
    end
  end

endmodule

>>> rtl/core/stc_div_stage.sv
module stc_div_stage
  import stc_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  logic  clk,
  input  logic  rst,
  input  divs_t din,
  output divs_t dout
);

  logic [DOTW-1:0] rs;
  logic            ge;

  always_comb begin
    rs = FIRST ? din.r : (din.r << 1);
    ge = (rs >= din.d);
  end

  always_ff @(posedge clk) begin
    dout.hit <= din.hit;
    dout.d   <= din.d;
    dout.r   <= ge ? (rs - din.d) : rs;
    dout.q   <= {din.q[QW-2:0], ge};
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
  end

endmodule
